FILE: design/brd_pkg.sv
// Shared types, constants and helpers for the binary range decoder.
// No dependencies; imported by every module of the block.
package brd_pkg;

  localparam int unsigned ProbW  = 15;
  localparam int unsigned WinW   = 8;
  localparam int unsigned StateW = 32;
  localparam int unsigned ShW    = 4;
  localparam int unsigned CntW   = 3;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgAddrW-1:0] CfgAddrZeroProb = 3'd0;

  localparam logic [CntW-1:0]   PrimeItems = 3'd4;
  localparam logic [ProbW-1:0]  ProbReset  = 15'd3277;
  localparam logic [StateW-1:0] RangeReset = 32'hFFFF_FFFF;
  localparam logic [StateW-1:0] CodeReset  = 32'h0000_0000;

  typedef struct packed {
    logic [StateW-1:0] interval_range;
    logic [StateW-1:0] code_value;
    logic [CntW-1:0]   prime_cnt;
  } dec_state_t;

  typedef struct packed {
    logic          symbol_bit;
    logic          symbol_valid;
    logic [ShW-1:0] bits_taken;
  } dec_result_t;

  // Leading zeros of the top window-sized slice, saturating at the window width.
  function automatic logic [ShW-1:0] lead_zeros_clamped(input logic [WinW-1:0] top);
    logic [ShW-1:0] n;
    logic           found;
    n     = ShW'(WinW);
    found = 1'b0;
    for (int i = WinW - 1; i >= 0; i--) begin
      if (!found && top[i]) begin
        n     = ShW'(WinW - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

FILE: design/brd_regs.sv
// Configuration register file of the binary range decoder (APB-style port).
// Depends on brd_pkg.
module brd_regs import brd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output logic [ProbW-1:0]    zero_probability
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == CfgAddrZeroProb);

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_probability <= ProbReset;
    end else if (wr_en) begin
      zero_probability <= pwdata[ProbW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == CfgAddrZeroProb) begin
      prdata = CfgDataW'(zero_probability);
    end
  end

endmodule

FILE: design/brd_step.sv
// One decode step: priming shift or bound/compare/renormalise of range and code.
// Depends on brd_pkg.
module brd_step import brd_pkg::*; (
  input  dec_state_t       state,
  input  logic [ProbW-1:0] zero_probability,
  input  logic [WinW-1:0]  window_bits,
  output dec_state_t       state_next,
  output dec_result_t      result
);

  logic [StateW-ProbW-1:0] range_hi;
  logic [StateW-1:0]       bound;
  logic                    bit_one;
  logic [StateW-1:0]       rsel;
  logic [StateW-1:0]       csel;
  logic [ShW-1:0]          sh;
  logic [StateW-1:0]       win_ext;
  logic                    primed;

  assign range_hi = state.interval_range[StateW-1:ProbW];
  // 17 x 15 bit product fits the 32-bit result exactly
  assign bound    = StateW'(range_hi) * StateW'(zero_probability);
  assign bit_one  = state.code_value >= bound;
  assign rsel     = bit_one ? state.interval_range - bound : bound;
  assign csel     = bit_one ? state.code_value - bound : state.code_value;
  assign sh       = lead_zeros_clamped(rsel[StateW-1:StateW-WinW]);
  assign win_ext  = StateW'(window_bits);
  assign primed   = (state.prime_cnt == PrimeItems);

  always_comb begin
    state_next = state;
    result     = '0;
    if (!primed) begin
      state_next.code_value = {state.code_value[StateW-WinW-1:0], window_bits};
      state_next.prime_cnt  = state.prime_cnt + CntW'(1);
      result.bits_taken     = ShW'(WinW);
    end else begin
      state_next.interval_range = rsel << sh;
      state_next.code_value     = (csel << sh) | (win_ext >> (ShW'(WinW) - sh));
      result.symbol_bit         = bit_one;
      result.symbol_valid       = 1'b1;
      result.bits_taken         = sh;
    end
  end

endmodule

FILE: design/binary_range_decoder_fixed_prob_unit.sv
// Binary range decoder with a fixed Q15 zero probability: top level.
// Depends on brd_pkg, brd_regs and brd_step.
//
// Takes one request per clock unless the result side stalls: each request
// carries the next eight stream bits (bit 7 earliest) and yields exactly
// one result. The first four requests after reset prime the 32-bit code
// register and report eight bits taken with no symbol; every later request
// decodes one biased bit and reports how many window bits the renormalisation
// consumed, which is how far the caller must advance its stream pointer
// before forming the next window. A request is held in an input register
// until the result register is free or draining; then a single pass of
// logic (17x15 multiply, compare, subtract, leading-zero count and shift)
// updates range and code and loads the result register. Throughput is one
// request per clock while m_tready is high, set by the decode path that
// feeds range and code back to itself. The result register lets a new
// request enter while a finished result still waits for m_tready.
// Write zero_probability (byte address 0) only while the block is idle.
module binary_range_decoder_fixed_prob_unit import brd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // request side
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] window_bits
  // result side
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [0] symbol_bit, [4:1] bits_taken, [7:5] zero
  output logic                m_tuser,   // [0] symbol_valid
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic [ProbW-1:0] zero_probability;
  logic             in_full;
  logic [WinW-1:0]  in_window;
  logic             advance;
  dec_state_t       state;
  dec_state_t       state_next;
  dec_result_t      result;
  dec_result_t      out_result;

  brd_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .zero_probability (zero_probability)
  );

  brd_step u_step (
    .state            (state),
    .zero_probability (zero_probability),
    .window_bits      (in_window),
    .state_next       (state_next),
    .result           (result)
  );

  // Decode the held request whenever the result register is free or draining.
  assign advance  = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || advance;

  // Input register: hold the request until it is decoded.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_window <= s_tdata[WinW-1:0];
    end
  end

  // Decoder state: advance once per decoded request.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.interval_range <= RangeReset;
      state.code_value     <= CodeReset;
      state.prime_cnt      <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tdata = {3'b000, out_result.bits_taken, out_result.symbol_bit};
  assign m_tuser = out_result.symbol_valid;

endmodule
